@@ sv/meu_pkg.sv @@
// ----------------------------------------------------------------------------
// meu_pkg
// Shared types and constants of the monomial exponent unit: operation codes,
// port widths and the control word that travels down the lane cell chain.
// ----------------------------------------------------------------------------
package meu_pkg;

   // fixed port widths
   localparam int WORD_W = 64;
   localparam int FUNC_W = 2;
   localparam int SEL_W  = 3;

   // default geometry of the packed exponent word
   localparam int VARS_DEF     = 8;
   localparam int EXP_BITS_DEF = 8;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_COMPARE  = 2'd0,
      FUNC_MULTIPLY = 2'd1,
      FUNC_SUBST    = 2'd2
   } func_type;

   // control word handed from cell to cell
   typedef struct packed {
      logic              valid;    // word present in this stage
      func_type          func;     // operation of the word
      logic              sel_ok;   // substitute lane not yet reached
      logic [SEL_W-1:0]  sel_cnt;  // cells left until the substitute lane
      logic              decided;  // lane scan found a first difference
      logic              scan_lt;  // outcome of that first difference
      logic              ovf;      // some lane saturated so far
   } ctl_type;

endpackage

@@ sv/monomial_exponent_unit.sv @@
// ----------------------------------------------------------------------------
// monomial_exponent_unit
// Graded order compare, multiply and variable substitution on packed
// exponent vectors, built as a chain of one cell per lane.
// ----------------------------------------------------------------------------
// Each word walks through a chain of VARS lane cells, one lane per cell, and
// then an output register where the order decision is resolved. The chain
// advances as a whole whenever the output register is free or being read, so
// one word is accepted every cycle while rsp_ready stays high; a stalled output
// holds the whole chain. Lanes beyond bit 63 read as zero and their result
// bits are dropped.
module monomial_exponent_unit #(
   parameter int VARS     = meu_pkg::VARS_DEF,
   parameter int EXP_BITS = meu_pkg::EXP_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [meu_pkg::FUNC_W-1:0]   req_func,
   input  logic [meu_pkg::WORD_W-1:0]   req_left_exponents,
   input  logic [meu_pkg::WORD_W-1:0]   req_right_exponents,
   input  logic [meu_pkg::SEL_W-1:0]    req_var_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_less_than,
   output logic [meu_pkg::WORD_W-1:0]   rsp_result_exponents,
   output logic                         rsp_overflow
);
   import meu_pkg::*;

   localparam int RES_W = VARS * EXP_BITS;
   localparam int PAD_W = (RES_W > WORD_W) ? RES_W : WORD_W;
   localparam int DEG_W = $clog2(VARS * ((1 << EXP_BITS) - 1) + 1);
   localparam int CNT_W = $clog2(VARS + 1);

   logic                advance;
   logic [PAD_W-1:0]    left_pad, right_pad, res_pad;
   logic [EXP_BITS-1:0] p_sel;
   logic                sel_ok;
   ctl_type             ctl_head;

   ctl_type             ctl_c   [VARS+1];
   logic [RES_W-1:0]    left_c  [VARS+1];
   logic [RES_W-1:0]    right_c [VARS+1];
   logic [RES_W-1:0]    res_c   [VARS+1];
   logic [EXP_BITS-1:0] p_c     [VARS+1];
   logic [DEG_W-1:0]    deg_l_c [VARS+1];
   logic [DEG_W-1:0]    deg_r_c [VARS+1];
   logic [CNT_W-1:0]    nz_l_c  [VARS+1];
   logic [CNT_W-1:0]    nz_r_c  [VARS+1];

   logic                order_lt;
   logic                rsp_valid_ff;
   logic                rsp_less_than_ff, rsp_less_than_in;
   logic [WORD_W-1:0]   rsp_result_ff;
   logic                rsp_overflow_ff;

   // the chain moves when the output register can take a word
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // operands widened or trimmed to the lane grid
   assign left_pad  = PAD_W'(req_left_exponents);
   assign right_pad = PAD_W'(req_right_exponents);
   assign sel_ok    = int'(req_var_index) < VARS;

   // exponent of the substituted variable
   always_comb begin
      p_sel = '0;
      for (int i = 0; i < VARS; i++) begin
         if (i == int'(req_var_index)) p_sel = left_pad[i*EXP_BITS +: EXP_BITS];
      end
   end

   // head of the chain
   always_comb begin
      ctl_head         = '0;
      ctl_head.valid   = req_valid;
      ctl_head.func    = func_type'(req_func);
      ctl_head.sel_ok  = sel_ok;
      ctl_head.sel_cnt = req_var_index;
   end
   assign ctl_c[0]   = ctl_head;
   assign left_c[0]  = left_pad[RES_W-1:0];
   assign right_c[0] = right_pad[RES_W-1:0];
   assign res_c[0]   = '0;
   assign p_c[0]     = sel_ok ? p_sel : '0;
   assign deg_l_c[0] = '0;
   assign deg_r_c[0] = '0;
   assign nz_l_c[0]  = '0;
   assign nz_r_c[0]  = '0;

   // one cell per lane
   for (genvar g = 0; g < VARS; g++) begin : g_cell
      meu_lane_cell #(
         .VARS     (VARS),
         .EXP_BITS (EXP_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl_in    (ctl_c[g]),
         .left_in   (left_c[g]),
         .right_in  (right_c[g]),
         .res_in    (res_c[g]),
         .p_in      (p_c[g]),
         .deg_l_in  (deg_l_c[g]),
         .deg_r_in  (deg_r_c[g]),
         .nz_l_in   (nz_l_c[g]),
         .nz_r_in   (nz_r_c[g]),
         .ctl_out   (ctl_c[g+1]),
         .left_out  (left_c[g+1]),
         .right_out (right_c[g+1]),
         .res_out   (res_c[g+1]),
         .p_out     (p_c[g+1]),
         .deg_l_out (deg_l_c[g+1]),
         .deg_r_out (deg_r_c[g+1]),
         .nz_l_out  (nz_l_c[g+1]),
         .nz_r_out  (nz_r_c[g+1])
      );
   end

   // degree first, then nonzero count, then the lane scan
   always_comb begin
      priority if (deg_l_c[VARS] != deg_r_c[VARS]) order_lt = deg_l_c[VARS] < deg_r_c[VARS];
      else if (nz_l_c[VARS] != nz_r_c[VARS])       order_lt = nz_l_c[VARS] < nz_r_c[VARS];
      else order_lt = ctl_c[VARS].decided && ctl_c[VARS].scan_lt;
      rsp_less_than_in = (ctl_c[VARS].func == FUNC_COMPARE) && order_lt;
   end

   assign res_pad = PAD_W'(res_c[VARS]);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl_c[VARS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_less_than_ff <= rsp_less_than_in;
         rsp_result_ff    <= res_pad[WORD_W-1:0];
         rsp_overflow_ff  <= ctl_c[VARS].ovf;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_less_than        = rsp_less_than_ff;
   assign rsp_result_exponents = rsp_result_ff;
   assign rsp_overflow         = rsp_overflow_ff;

endmodule

@@ sv/meu_lane_cell.sv @@
// ----------------------------------------------------------------------------
// meu_lane_cell
// One lane of the chain: takes the lowest lane of the shifted operands,
// adds it to the degree and nonzero counts, updates the first-difference
// scan, forms the saturated product or substitute lane and passes all of it
// to the next cell through registers.
// ----------------------------------------------------------------------------
module meu_lane_cell #(
   parameter int VARS     = meu_pkg::VARS_DEF,
   parameter int EXP_BITS = meu_pkg::EXP_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          advance,
   input  meu_pkg::ctl_type                              ctl_in,
   input  logic [VARS*EXP_BITS-1:0]                      left_in,
   input  logic [VARS*EXP_BITS-1:0]                      right_in,
   input  logic [VARS*EXP_BITS-1:0]                      res_in,
   input  logic [EXP_BITS-1:0]                           p_in,
   input  logic [$clog2(VARS*((1<<EXP_BITS)-1)+1)-1:0]   deg_l_in,
   input  logic [$clog2(VARS*((1<<EXP_BITS)-1)+1)-1:0]   deg_r_in,
   input  logic [$clog2(VARS+1)-1:0]                     nz_l_in,
   input  logic [$clog2(VARS+1)-1:0]                     nz_r_in,
   output meu_pkg::ctl_type                              ctl_out,
   output logic [VARS*EXP_BITS-1:0]                      left_out,
   output logic [VARS*EXP_BITS-1:0]                      right_out,
   output logic [VARS*EXP_BITS-1:0]                      res_out,
   output logic [EXP_BITS-1:0]                           p_out,
   output logic [$clog2(VARS*((1<<EXP_BITS)-1)+1)-1:0]   deg_l_out,
   output logic [$clog2(VARS*((1<<EXP_BITS)-1)+1)-1:0]   deg_r_out,
   output logic [$clog2(VARS+1)-1:0]                     nz_l_out,
   output logic [$clog2(VARS+1)-1:0]                     nz_r_out
);
   import meu_pkg::*;

   localparam int RES_W = VARS * EXP_BITS;
   localparam int DEG_W = $clog2(VARS * ((1 << EXP_BITS) - 1) + 1);
   localparam int CNT_W = $clog2(VARS + 1);
   localparam int SUM_W = 2 * EXP_BITS + 1;
   localparam logic [SUM_W-1:0] LANE_MAX = SUM_W'((1 << EXP_BITS) - 1);

   logic [EXP_BITS-1:0] x, y;
   logic                hit;
   logic [SUM_W-1:0]    sum;
   logic                sat;
   logic [EXP_BITS-1:0] lane;

   ctl_type             ctl_in_n, ctl_ff;
   logic [RES_W-1:0]    left_ff, right_ff, res_ff;
   logic [RES_W-1:0]    res_nxt;
   logic [EXP_BITS-1:0] p_ff;
   logic [DEG_W-1:0]    deg_l_ff, deg_r_ff, deg_l_nxt, deg_r_nxt;
   logic [CNT_W-1:0]    nz_l_ff, nz_r_ff, nz_l_nxt, nz_r_nxt;

   // current lane sits at the bottom of the shifted operands
   assign x   = left_in[EXP_BITS-1:0];
   assign y   = right_in[EXP_BITS-1:0];
   assign hit = ctl_in.sel_ok && (ctl_in.sel_cnt == '0);

   // lane arithmetic with saturation
   always_comb begin
      unique case (ctl_in.func)
         FUNC_MULTIPLY: sum = SUM_W'(x) + SUM_W'(y);
         FUNC_SUBST:    sum = (hit ? '0 : SUM_W'(x)) + SUM_W'(p_in) * SUM_W'(y);
         default:       sum = '0;
      endcase
      sat  = sum > LANE_MAX;
      lane = sat ? LANE_MAX[EXP_BITS-1:0] : sum[EXP_BITS-1:0];
   end

   // degree, nonzero counts and first-difference scan
   always_comb begin
      deg_l_nxt = deg_l_in + DEG_W'(x);
      deg_r_nxt = deg_r_in + DEG_W'(y);
      nz_l_nxt  = nz_l_in + CNT_W'(x != '0);
      nz_r_nxt  = nz_r_in + CNT_W'(y != '0);
      res_nxt   = (res_in >> EXP_BITS) | (RES_W'(lane) << (RES_W - EXP_BITS));

      ctl_in_n         = ctl_in;
      ctl_in_n.sel_ok  = ctl_in.sel_ok && !hit;
      ctl_in_n.sel_cnt = ctl_in.sel_cnt - 1'b1;
      ctl_in_n.ovf     = ctl_in.ovf || sat;
      if (!ctl_in.decided && (x != y)) begin
         ctl_in_n.decided = 1'b1;
         // a zero lane against a nonzero one puts the zero side later
         priority if (x == '0) ctl_in_n.scan_lt = 1'b0;
         else if (y == '0)     ctl_in_n.scan_lt = 1'b1;
         else                  ctl_in_n.scan_lt = x < y;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in_n;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in >> EXP_BITS;
         right_ff <= right_in >> EXP_BITS;
         res_ff   <= res_nxt;
         p_ff     <= p_in;
         deg_l_ff <= deg_l_nxt;
         deg_r_ff <= deg_r_nxt;
         nz_l_ff  <= nz_l_nxt;
         nz_r_ff  <= nz_r_nxt;
      end
   end

   assign ctl_out   = ctl_ff;
   assign left_out  = left_ff;
   assign right_out = right_ff;
   assign res_out   = res_ff;
   assign p_out     = p_ff;
   assign deg_l_out = deg_l_ff;
   assign deg_r_out = deg_r_ff;
   assign nz_l_out  = nz_l_ff;
   assign nz_r_out  = nz_r_ff;

endmodule

@@ bench/tb_monomial_exponent_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_monomial_exponent_unit
// Self-checking bench for the monomial exponent unit. Directed words hit the
// order rules, lane saturation, substitution corners and the unused opcode,
// then mixed random traffic runs with random idle gaps on the request side
// and random stalls on the response side. Every response word is compared
// against a predictor that runs in lockstep with the request handshakes.
// ----------------------------------------------------------------------------
module tb_monomial_exponent_unit;

   import meu_pkg::*;

   localparam int VARS     = VARS_DEF;
   localparam int EXP_BITS = EXP_BITS_DEF;
   localparam logic [WORD_W-1:0] LANE_MAX = (64'd1 << EXP_BITS) - 64'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   // expected response word
   typedef struct packed {
      logic              lt;
      logic [WORD_W-1:0] exps;
      logic              ovf;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [WORD_W-1:0]   req_left_exponents = '0;
   logic [WORD_W-1:0]   req_right_exponents = '0;
   logic [SEL_W-1:0]    req_var_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_less_than;
   logic [WORD_W-1:0]   rsp_result_exponents;
   logic                rsp_overflow;

   outcome_type pending_outcomes[$];
   int          error_count = 0;
   bit          steady_flow = 1'b0;
   int          stall_left = 0;
   int          stall_roll;

   monomial_exponent_unit #(
      .VARS     (VARS),
      .EXP_BITS (EXP_BITS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_left_exponents   (req_left_exponents),
      .req_right_exponents  (req_right_exponents),
      .req_var_index        (req_var_index),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_less_than        (rsp_less_than),
      .rsp_result_exponents (rsp_result_exponents),
      .rsp_overflow         (rsp_overflow)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #(64'd20_000_000);
      $display("Regression FAIL");
      $finish;
   end

   // exponent of lane i, zero for lanes lying above the word
   function automatic logic [WORD_W-1:0] lane_of(input logic [WORD_W-1:0] w, input int i);
      if (i * EXP_BITS >= WORD_W) return '0;
      return (w >> (i * EXP_BITS)) & LANE_MAX;
   endfunction

   // graded order: degree, then nonzero count, then first differing lane
   function automatic logic order_precedes(input logic [WORD_W-1:0] a,
                                           input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] x, y;
      int unsigned deg_a, deg_b, nz_a, nz_b;
      deg_a = 0; deg_b = 0; nz_a = 0; nz_b = 0;
      for (int i = 0; i < VARS; i++) begin
         x = lane_of(a, i);
         y = lane_of(b, i);
         deg_a += x;
         deg_b += y;
         nz_a += (x != 0);
         nz_b += (y != 0);
      end
      if (deg_a != deg_b) return deg_a < deg_b;
      if (nz_a != nz_b) return nz_a < nz_b;
      for (int i = 0; i < VARS; i++) begin
         x = lane_of(a, i);
         y = lane_of(b, i);
         if (x == 0 && y != 0) return 1'b0;
         if (y == 0 && x != 0) return 1'b1;
         if (x != y) return x < y;
      end
      return 1'b0;
   endfunction

   // expected response for one request word
   function automatic outcome_type predict_outcome(input logic [FUNC_W-1:0] f,
                                                   input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b,
                                                   input logic [SEL_W-1:0]  sel);
      outcome_type       o;
      logic [WORD_W-1:0] sums [VARS];
      logic [WORD_W-1:0] p;
      logic              hit;
      logic              arith;
      o = '0;
      arith = 1'b0;
      case (f)
         FUNC_COMPARE: begin
            o.lt = order_precedes(a, b);
         end
         FUNC_MULTIPLY: begin
            arith = 1'b1;
            for (int i = 0; i < VARS; i++) sums[i] = lane_of(a, i) + lane_of(b, i);
         end
         FUNC_SUBST: begin
            arith = 1'b1;
            hit = (int'(sel) < VARS);
            p = hit ? lane_of(a, int'(sel)) : '0;
            for (int i = 0; i < VARS; i++) begin
               sums[i] = (hit && i == int'(sel)) ? '0 : lane_of(a, i);
               sums[i] = sums[i] + p * lane_of(b, i);
            end
         end
         default: ;
      endcase
      // saturate each lane and pack
      if (arith) begin
         for (int i = 0; i < VARS; i++) begin
            if (sums[i] > LANE_MAX) begin
               o.ovf = 1'b1;
               sums[i] = LANE_MAX;
            end
            if (i * EXP_BITS < WORD_W) o.exps = o.exps | (sums[i] << (i * EXP_BITS));
         end
      end
      return o;
   endfunction

   // predict on request handshake, check on response handshake
   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_outcomes.push_back(predict_outcome(req_func, req_left_exponents,
                                                       req_right_exponents, req_var_index));
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               error_count++;
               $display("%0t unexpected word: less_than %0b result %h overflow %0b",
                        $time, rsp_less_than, rsp_result_exponents, rsp_overflow);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_less_than !== want.lt) begin
                  error_count++;
                  $display("%0t less_than mismatch: expected %0b actual %0b",
                           $time, want.lt, rsp_less_than);
               end
               if (rsp_result_exponents !== want.exps) begin
                  error_count++;
                  $display("%0t result_exponents mismatch: expected %h actual %h",
                           $time, want.exps, rsp_result_exponents);
               end
               if (rsp_overflow !== want.ovf) begin
                  error_count++;
                  $display("%0t overflow mismatch: expected %0b actual %0b",
                           $time, want.ovf, rsp_overflow);
               end
            end
         end
      end
   end

   // response side stalls, mostly short with an occasional long one
   always @(posedge clock) begin
      if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 75) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(5, 20);
         end
      end
   end

   // idle cycles before the next request word
   function automatic int next_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // send one request word and wait for it to be taken
   task automatic send_word(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b, input logic [SEL_W-1:0] sel);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= f;
      req_left_exponents  <= a;
      req_right_exponents <= b;
      req_var_index       <= sel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // exponent biased toward zero, small values and the top of the range
   function automatic logic [WORD_W-1:0] random_exponent();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return '0;
      if (r < 6) return $urandom_range(1, 3);
      if (r == 6) return LANE_MAX;
      if (r == 7) return LANE_MAX - 1;
      return $urandom & LANE_MAX;
   endfunction

   function automatic logic [WORD_W-1:0] random_monomial();
      logic [WORD_W-1:0] w;
      w = '0;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      for (int i = 0; i < VARS; i++)
         if (i * EXP_BITS < WORD_W) w = w | (random_exponent() << (i * EXP_BITS));
      return w;
   endfunction

   // partner for compare that often ties on degree so the lane scan decides
   function automatic logic [WORD_W-1:0] compare_partner(input logic [WORD_W-1:0] a);
      logic [WORD_W-1:0] b, x, y;
      int i, j, k;
      b = a;
      case ($urandom_range(0, 4))
         0: b = random_monomial();
         1: b = a;
         2: begin
            // permute lanes: same degree and nonzero count
            k = $urandom_range(1, 3);
            repeat (k) begin
               i = $urandom_range(0, VARS - 1);
               j = $urandom_range(0, VARS - 1);
               x = lane_of(b, i);
               y = lane_of(b, j);
               b = b & ~(LANE_MAX << (i * EXP_BITS)) & ~(LANE_MAX << (j * EXP_BITS));
               b = b | (y << (i * EXP_BITS)) | (x << (j * EXP_BITS));
            end
         end
         3: begin
            // move one unit between lanes: same degree
            i = $urandom_range(0, VARS - 1);
            j = $urandom_range(0, VARS - 1);
            if (i != j && lane_of(b, i) != 0 && lane_of(b, j) != LANE_MAX) begin
               b = b - (64'd1 << (i * EXP_BITS));
               b = b + (64'd1 << (j * EXP_BITS));
            end
         end
         default: b = {$urandom, $urandom};
      endcase
      return b;
   endfunction

   // order rules: degree, nonzero count, lane scan, equality
   task automatic test_compare_order();
      send_word(FUNC_COMPARE, '0, '0, 3'd0);
      send_word(FUNC_COMPARE, '0, 64'h01, 3'd5);
      send_word(FUNC_COMPARE, ALL_ONES, ALL_ONES, 3'd7);
      send_word(FUNC_COMPARE, 64'h02, 64'h0101, 3'd0);
      send_word(FUNC_COMPARE, 64'h0101, 64'h02, 3'd0);
      send_word(FUNC_COMPARE, 64'h0100, 64'h0001, 3'd0);
      send_word(FUNC_COMPARE, 64'h0001, 64'h0100, 3'd0);
      send_word(FUNC_COMPARE, 64'h0201, 64'h0102, 3'd0);
      send_word(FUNC_COMPARE, ALL_ONES, 64'hFEFF_FFFF_FFFF_FFFF, 3'd0);
      send_word(FUNC_COMPARE, 64'hFEFF_FFFF_FFFF_FFFF, ALL_ONES, 3'd0);
   endtask

   // lane sums below, at and above saturation
   task automatic test_multiply_lanes();
      send_word(FUNC_MULTIPLY, '0, '0, 3'd0);
      send_word(FUNC_MULTIPLY, ALL_ONES, ALL_ONES, 3'd7);
      send_word(FUNC_MULTIPLY, 64'hFE00_0000_0000_0001, 64'h0100_0000_0000_00FE, 3'd0);
      send_word(FUNC_MULTIPLY, 64'hFF00_0000_0000_0000, 64'h0100_0000_0000_0000, 3'd0);
   endtask

   // first and last lane, zero power, saturation, self lane in the substitute
   task automatic test_substitute_lanes();
      send_word(FUNC_SUBST, 64'h0102_0304_0506_0700, 64'h0302_0100_0000_0001, 3'd0);
      send_word(FUNC_SUBST, 64'h0300_0000_0000_0201, 64'h0001_0000_0000_0102, 3'd7);
      send_word(FUNC_SUBST, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 3'd3);
      send_word(FUNC_SUBST, 64'h0000_0000_FF00_0000, 64'h0101_0101_0101_0101, 3'd3);
      send_word(FUNC_SUBST, 64'h0000_0000_0000_0510, 64'h0000_0000_0000_0302, 3'd1);
   endtask

   // unused opcode answers with an all-zero word
   task automatic test_unused_code();
      send_word(FUNC_UNUSED, ALL_ONES, ALL_ONES, 3'd7);
      send_word(FUNC_UNUSED, 64'h01, 64'h02, 3'd2);
   endtask

   // mixed random traffic with bursts of back-to-back words
   task automatic test_random_traffic(input int count);
      logic [WORD_W-1:0] a, b;
      logic [FUNC_W-1:0] f;
      logic [SEL_W-1:0]  sel;
      int                pick;
      for (int n = 0; n < count; n++) begin
         steady_flow = ((n % 300) < 40);
         pick = $urandom_range(0, 99);
         sel  = $urandom_range(0, 7);
         a    = random_monomial();
         if (pick < 40) begin
            f = FUNC_COMPARE;
            b = compare_partner(a);
         end else if (pick < 65) begin
            f = FUNC_MULTIPLY;
            b = random_monomial();
         end else if (pick < 96) begin
            f = FUNC_SUBST;
            b = random_monomial();
         end else begin
            f = FUNC_UNUSED;
            b = {$urandom, $urandom};
         end
         send_word(f, a, b, sel);
      end
      steady_flow = 1'b0;
   endtask

   // sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_compare_order();
      test_multiply_lanes();
      test_substitute_lanes();
      test_unused_code();
      test_random_traffic(1400);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (VARS + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/meu_pkg.sv
sv/meu_lane_cell.sv
sv/monomial_exponent_unit.sv
bench/tb_monomial_exponent_unit.sv
